// File: src/eis_pkg.sv
// Shared types, state and command codes, and sizes for the engine ignition sequencer.
package eis_pkg;

   localparam int STATE_BITS     = 5;
   localparam int CMD_BITS       = 3;
   localparam int CFG_BITS       = 32;
   localparam int CFG_INDEX_BITS = 3;
   localparam int TIME_BITS_DEF  = 32;

   localparam logic [CFG_BITS-1:0] CFG_RESET_MS   = 32'd10000;
   localparam logic [CFG_BITS-1:0] FIXED_STAGE_MS = 32'd10000;

   typedef logic [STATE_BITS-1:0]     state_type;
   typedef logic [CMD_BITS-1:0]       cmd_type;
   typedef logic [CFG_INDEX_BITS-1:0] cfg_index_type;

   // Engine states: the normal sequence up to shutoff in order, then the abort states and depressurize
   localparam state_type ST_IDLE             = 5'd0;
   localparam state_type ST_CLEAR_TO_IGNITE  = 5'd1;
   localparam state_type ST_PRECHILL         = 5'd2;
   localparam state_type ST_IGNITER          = 5'd3;
   localparam state_type ST_BURN_START_OX    = 5'd4;
   localparam state_type ST_BURN_START_FUEL  = 5'd5;
   localparam state_type ST_BURN             = 5'd6;
   localparam state_type ST_BURN_STOP_OX     = 5'd7;
   localparam state_type ST_BURN_STOP_FUEL   = 5'd8;
   localparam state_type ST_WAIT_PASSIVATE   = 5'd9;
   localparam state_type ST_SEPARATION_DELAY = 5'd10;
   localparam state_type ST_PASSIVATE_FUEL   = 5'd11;
   localparam state_type ST_PASSIVATE_CLOSE  = 5'd12;
   localparam state_type ST_PASSIVATE_OX     = 5'd13;
   localparam state_type ST_SHUTOFF          = 5'd14;
   localparam state_type ST_ABORT_GROUND     = 5'd15;
   localparam state_type ST_GROUND_ABORT_OX  = 5'd16;
   localparam state_type ST_GROUND_ABORT_FUEL= 5'd17;
   localparam state_type ST_ABORT_FLIGHT     = 5'd18;
   localparam state_type ST_FLIGHT_ABORT_OX  = 5'd19;
   localparam state_type ST_FLIGHT_ABORT_FUEL= 5'd20;
   localparam state_type ST_DEPRESSURIZE     = 5'd21;

   // Command codes
   localparam cmd_type CMD_NONE      = 3'd0;
   localparam cmd_type CMD_CLEAR     = 3'd1;
   localparam cmd_type CMD_IGNITE    = 3'd2;
   localparam cmd_type CMD_ABORT     = 3'd3;
   localparam cmd_type CMD_PASSIVATE = 3'd4;
   localparam cmd_type CMD_RESET     = 3'd5;

   // Register indexes
   localparam cfg_index_type REG_PRECHILL      = 3'd0;
   localparam cfg_index_type REG_IGNITER       = 3'd1;
   localparam cfg_index_type REG_IGN_DELAY     = 3'd2;
   localparam cfg_index_type REG_RAMPUP        = 3'd3;
   localparam cfg_index_type REG_BURN_LIMIT    = 3'd4;
   localparam cfg_index_type REG_CUTOFF_DELAY  = 3'd5;
   localparam cfg_index_type REG_NO_COMMS      = 3'd6;
   localparam cfg_index_type REG_FLIGHT_HOLD   = 3'd7;

   typedef struct packed {
      logic [CFG_BITS-1:0] prechill_time;
      logic [CFG_BITS-1:0] igniter_time;
      logic [CFG_BITS-1:0] ignition_delay;
      logic [CFG_BITS-1:0] rampup_time;
      logic [CFG_BITS-1:0] burn_limit;
      logic [CFG_BITS-1:0] cutoff_delay;
      logic [CFG_BITS-1:0] no_comms_passivation;
      logic [CFG_BITS-1:0] abort_flight_hold;
   } cfg_type;

   typedef struct packed {
      state_type seq_state;
      logic      oxidizer_valve_open;
      logic      fuel_valve_open;
      logic      igniter_on;
      logic      state_changed;
   } result_type;

endpackage

// File: src/eis_cfg_regs.sv
// Stage duration registers written through the configuration channel.
module eis_cfg_regs (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  eis_pkg::cfg_index_type wr_index,
   input  logic [eis_pkg::CFG_BITS-1:0] wr_data,
   output eis_pkg::cfg_type       cfg
);
   import eis_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write word into its register
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_PRECHILL:     cfg_in.prechill_time        = wr_data;
            REG_IGNITER:      cfg_in.igniter_time         = wr_data;
            REG_IGN_DELAY:    cfg_in.ignition_delay       = wr_data;
            REG_RAMPUP:       cfg_in.rampup_time          = wr_data;
            REG_BURN_LIMIT:   cfg_in.burn_limit           = wr_data;
            REG_CUTOFF_DELAY: cfg_in.cutoff_delay         = wr_data;
            REG_NO_COMMS:     cfg_in.no_comms_passivation = wr_data;
            REG_FLIGHT_HOLD:  cfg_in.abort_flight_hold    = wr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= {8{CFG_RESET_MS}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/eis_core.sv
// Engine state register, stage timer compare, next-state decode and valve latches.
module eis_core #(
   parameter int TIME_BITS = eis_pkg::TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [TIME_BITS-1:0] now_ms,
   input  eis_pkg::cmd_type     command,
   input  eis_pkg::cfg_type     cfg,
   output eis_pkg::result_type  result
);
   import eis_pkg::*;

   localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

   state_type            state_ff, state_in;
   logic [TIME_BITS-1:0] entry_ff, entry_in;
   logic                 ox_ff, ox_in;
   logic                 fuel_ff, fuel_in;
   logic                 ign_ff, ign_in;
   logic [TIME_BITS-1:0] elapsed;
   logic [CMP_BITS-1:0]  elapsed_ext;
   state_type            next_state;
   logic                 abort_cmd;
   logic                 reset_cmd;
   logic                 changed;

   function automatic logic reached(input logic [CMP_BITS-1:0] el,
                                    input logic [CFG_BITS-1:0] dur);
      reached = (el >= CMP_BITS'(dur));
   endfunction

   // Elapsed time in the current stage, modulo the time width
   assign elapsed     = now_ms - entry_ff;
   assign elapsed_ext = CMP_BITS'(elapsed);
   assign abort_cmd   = (command == CMD_ABORT);
   assign reset_cmd   = (command == CMD_RESET);

   // Next-state decode; abort and reset checks come first where a state has them
   always_comb begin
      next_state = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (command == CMD_CLEAR) next_state = ST_CLEAR_TO_IGNITE;
         ST_CLEAR_TO_IGNITE:
            if (abort_cmd) next_state = ST_ABORT_GROUND;
            else if (command == CMD_IGNITE) next_state = ST_PRECHILL;
         ST_PRECHILL:
            if (abort_cmd) next_state = ST_ABORT_GROUND;
            else if (reached(elapsed_ext, cfg.prechill_time)) next_state = ST_IGNITER;
         ST_IGNITER:
            if (abort_cmd) next_state = ST_ABORT_GROUND;
            else if (reached(elapsed_ext, cfg.igniter_time)) next_state = ST_BURN_START_OX;
         ST_BURN_START_OX:
            if (abort_cmd) next_state = ST_ABORT_GROUND;
            else if (reached(elapsed_ext, cfg.ignition_delay)) next_state = ST_BURN_START_FUEL;
         ST_BURN_START_FUEL:
            if (abort_cmd) next_state = ST_ABORT_GROUND;
            else if (reached(elapsed_ext, cfg.rampup_time)) next_state = ST_BURN;
         ST_BURN:
            if (abort_cmd) next_state = ST_ABORT_FLIGHT;
            else if (reached(elapsed_ext, cfg.burn_limit)) next_state = ST_BURN_STOP_OX;
         ST_BURN_STOP_OX:
            if (abort_cmd) next_state = ST_ABORT_FLIGHT;
            else if (reached(elapsed_ext, cfg.cutoff_delay)) next_state = ST_BURN_STOP_FUEL;
         ST_BURN_STOP_FUEL:
            next_state = abort_cmd ? ST_ABORT_FLIGHT : ST_WAIT_PASSIVATE;
         ST_WAIT_PASSIVATE:
            if (abort_cmd) next_state = ST_ABORT_FLIGHT;
            else if (command == CMD_PASSIVATE ||
                     reached(elapsed_ext, cfg.no_comms_passivation))
               next_state = ST_SEPARATION_DELAY;
         ST_SEPARATION_DELAY:
            if (reached(elapsed_ext, FIXED_STAGE_MS)) next_state = ST_PASSIVATE_FUEL;
         ST_PASSIVATE_FUEL:
            if (reached(elapsed_ext, FIXED_STAGE_MS)) next_state = ST_PASSIVATE_CLOSE;
         ST_PASSIVATE_CLOSE:
            if (reached(elapsed_ext, FIXED_STAGE_MS)) next_state = ST_PASSIVATE_OX;
         ST_PASSIVATE_OX:
            if (reached(elapsed_ext, FIXED_STAGE_MS)) next_state = ST_SHUTOFF;
         ST_SHUTOFF:
            if (reached(elapsed_ext, FIXED_STAGE_MS)) next_state = ST_DEPRESSURIZE;
         ST_ABORT_GROUND:
            next_state = ST_GROUND_ABORT_OX;
         ST_GROUND_ABORT_OX:
            if (reset_cmd) next_state = ST_IDLE;
            else if (reached(elapsed_ext, cfg.cutoff_delay)) next_state = ST_GROUND_ABORT_FUEL;
         ST_GROUND_ABORT_FUEL:
            if (reset_cmd) next_state = ST_IDLE;
         ST_ABORT_FLIGHT:
            next_state = ST_FLIGHT_ABORT_OX;
         ST_FLIGHT_ABORT_OX:
            if (reached(elapsed_ext, cfg.cutoff_delay)) next_state = ST_FLIGHT_ABORT_FUEL;
         ST_FLIGHT_ABORT_FUEL:
            if (reached(elapsed_ext, cfg.abort_flight_hold)) next_state = ST_WAIT_PASSIVATE;
         ST_DEPRESSURIZE:
            if (reset_cmd) next_state = ST_IDLE;
         default:
            next_state = ST_ABORT_GROUND;
      endcase
   end

   assign changed = (next_state != state_ff);

   // Apply entry actions of the new state to the latches
   always_comb begin
      ox_in   = ox_ff;
      fuel_in = fuel_ff;
      ign_in  = ign_ff;
      if (changed) begin
         unique case (next_state)
            ST_PRECHILL:          ox_in = 1'b1;
            ST_IGNITER:           begin ox_in = 1'b0; ign_in = 1'b1; end
            ST_BURN_START_OX:     begin ox_in = 1'b1; ign_in = 1'b0; end
            ST_BURN_START_FUEL:   fuel_in = 1'b1;
            ST_BURN_STOP_OX:      ox_in = 1'b0;
            ST_BURN_STOP_FUEL:    fuel_in = 1'b0;
            ST_PASSIVATE_FUEL:    fuel_in = 1'b1;
            ST_PASSIVATE_CLOSE:   fuel_in = 1'b0;
            ST_PASSIVATE_OX:      ox_in = 1'b1;
            ST_SHUTOFF:           ox_in = 1'b0;
            ST_GROUND_ABORT_OX:   ox_in = 1'b0;
            ST_GROUND_ABORT_FUEL: fuel_in = 1'b0;
            ST_FLIGHT_ABORT_OX:   ox_in = 1'b0;
            ST_FLIGHT_ABORT_FUEL: fuel_in = 1'b0;
            ST_DEPRESSURIZE:      begin ox_in = 1'b1; fuel_in = 1'b1; end
            default:              ign_in = ign_ff;
         endcase
      end
   end

   assign state_in = next_state;
   assign entry_in = changed ? now_ms : entry_ff;

   // Advance the state on each processed word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         entry_ff <= '0;
         ox_ff    <= 1'b0;
         fuel_ff  <= 1'b0;
         ign_ff   <= 1'b0;
      end else if (step) begin
         state_ff <= state_in;
         entry_ff <= entry_in;
         ox_ff    <= ox_in;
         fuel_ff  <= fuel_in;
         ign_ff   <= ign_in;
      end
   end

   assign result.seq_state           = next_state;
   assign result.oxidizer_valve_open = ox_in;
   assign result.fuel_valve_open     = fuel_in;
   assign result.igniter_on          = ign_in;
   assign result.state_changed       = changed;

endmodule

// File: src/engine_ignition_sequencer.sv
// Top level of the engine ignition sequencer: input register, core and result register.
//
// One word per clock cycle in steady state, while rsp_ready does not stall the result. A
// request is captured in an input register; once the result register is free, the state
// update, stage timeout compare and valve actions run and land in the result register
// together with the new engine state, which offers the result on rsp_. The engine state
// register feeds back on itself through the next-state decode, which sets the rate. A request
// is taken whenever the input register is empty or hands its word to the result register at
// the same edge, so a stalled result holds back at most one more word. Configuration writes
// are accepted in every cycle and should only be issued while no request is in flight.
module engine_ignition_sequencer #(
   parameter int TIME_BITS = eis_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [TIME_BITS-1:0]          req_now_ms,
   input  eis_pkg::cmd_type              req_command,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output eis_pkg::state_type            rsp_seq_state,
   output logic                          rsp_oxidizer_valve_open,
   output logic                          rsp_fuel_valve_open,
   output logic                          rsp_igniter_on,
   output logic                          rsp_state_changed,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  eis_pkg::cfg_index_type        csr_index,
   input  logic [eis_pkg::CFG_BITS-1:0]  csr_wdata
);
   import eis_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [TIME_BITS-1:0] in_now_ff;
   cmd_type              in_cmd_ff;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff;
   result_type           core_result;
   cfg_type              cfg;
   logic                 out_free;
   logic                 step;
   logic                 req_fire;

   assign csr_ready = 1'b1;

   // Hand-off control between the two register stages
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !rsp_ready);

   eis_cfg_regs u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   eis_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .now_ms  (in_now_ff),
      .command (in_cmd_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   // Valid flags of both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture request word and result word
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_now_ff <= req_now_ms;
         in_cmd_ff <= req_command;
      end
      if (step) begin
         out_ff <= core_result;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_seq_state           = out_ff.seq_state;
   assign rsp_oxidizer_valve_open = out_ff.oxidizer_valve_open;
   assign rsp_fuel_valve_open     = out_ff.fuel_valve_open;
   assign rsp_igniter_on          = out_ff.igniter_on;
   assign rsp_state_changed       = out_ff.state_changed;

endmodule

// File: src/eis_checker.sv
// Port-level checks for the engine ignition sequencer, bound to the top level.
module eis_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input eis_pkg::state_type       rsp_seq_state,
   input logic                     rsp_oxidizer_valve_open,
   input logic                     rsp_fuel_valve_open,
   input logic                     rsp_igniter_on,
   input logic                     rsp_state_changed
);
   import eis_pkg::*;

   state_type last_state_ff;

   // Track the state of the last delivered result word
   always_ff @(posedge clock) begin
      if (reset) begin
         last_state_ff <= ST_IDLE;
      end else if (rsp_valid && rsp_ready) begin
         last_state_ff <= rsp_seq_state;
      end
   end

   // Stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seq_state) &&
         $stable(rsp_state_changed))
      else $error("result word changed while stalled");

   // Change flag agrees with the sequence of delivered states
   a_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> rsp_state_changed == (rsp_seq_state != last_state_ff))
      else $error("state_changed disagrees with state sequence");

   // Igniter stage has igniter on and oxidizer closed
   a_igniter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seq_state == ST_IGNITER |-> rsp_igniter_on &&
         !rsp_oxidizer_valve_open)
      else $error("igniter stage drive mismatch");

   // Burn has both valves open and igniter off
   a_burn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seq_state == ST_BURN |-> rsp_oxidizer_valve_open &&
         rsp_fuel_valve_open && !rsp_igniter_on)
      else $error("burn stage drive mismatch");

   // Depressurize leaves both valves open
   a_depress: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seq_state == ST_DEPRESSURIZE |-> rsp_oxidizer_valve_open &&
         rsp_fuel_valve_open)
      else $error("depressurize valve mismatch");

endmodule

bind engine_ignition_sequencer eis_checker u_eis_checker (.*);

// File: verif/tb_engine_ignition_sequencer.sv
// Self-checking testbench for the engine ignition sequencer: directed and random words.
module tb_engine_ignition_sequencer;
   import eis_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TW = TIME_BITS_DEF;

   // Command codes the block treats as no command
   localparam cmd_type CMD_SPARE_6 = 3'd6;
   localparam cmd_type CMD_SPARE_7 = 3'd7;

   typedef enum {DUR_ZERO, DUR_MAX, DUR_SMALL, DUR_MIXED} dur_mode_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [TW-1:0]    req_now_ms;
   cmd_type          req_command;
   logic             rsp_valid;
   logic             rsp_ready;
   state_type        rsp_seq_state;
   logic             rsp_oxidizer_valve_open;
   logic             rsp_fuel_valve_open;
   logic             rsp_igniter_on;
   logic             rsp_state_changed;
   logic             csr_valid;
   logic             csr_ready;
   cfg_index_type    csr_index;
   logic [CFG_BITS-1:0] csr_wdata;

   // Tracks the engine state and valve latches, and holds the words still to come back
   class ignition_checker;
      state_type           state_q;
      logic [TW-1:0]       entry_ms;
      logic                ox_latch;
      logic                fuel_latch;
      logic                ign_latch;
      logic [CFG_BITS-1:0] dur [0:REG_FLIGHT_HOLD];
      result_type          expected_words [$];
      int                  errors;

      function new();
         int i;
         for (i = REG_PRECHILL; i <= REG_FLIGHT_HOLD; i++)
            dur[i] = CFG_RESET_MS;
         state_q = ST_IDLE;
         entry_ms = '0;
         ox_latch = 1'b0;
         fuel_latch = 1'b0;
         ign_latch = 1'b0;
         errors = 0;
      endfunction

      function void write_reg(cfg_index_type idx, logic [CFG_BITS-1:0] val);
         dur[idx] = val;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // Advance the engine by one accepted word and queue the word it should return
      function void note_word(logic [TW-1:0] now, cmd_type cmd);
         logic [TW-1:0] elapsed;
         logic          is_abort;
         logic          is_reset;
         state_type     nxt;
         result_type    exp;
         elapsed = now - entry_ms;
         is_abort = (cmd == CMD_ABORT);
         is_reset = (cmd == CMD_RESET);
         nxt = state_q;
         case (state_q)
            ST_IDLE:
               if (cmd == CMD_CLEAR) nxt = ST_CLEAR_TO_IGNITE;
            ST_CLEAR_TO_IGNITE:
               if (is_abort) nxt = ST_ABORT_GROUND;
               else if (cmd == CMD_IGNITE) nxt = ST_PRECHILL;
            ST_PRECHILL:
               if (is_abort) nxt = ST_ABORT_GROUND;
               else if (elapsed >= dur[REG_PRECHILL]) nxt = ST_IGNITER;
            ST_IGNITER:
               if (is_abort) nxt = ST_ABORT_GROUND;
               else if (elapsed >= dur[REG_IGNITER]) nxt = ST_BURN_START_OX;
            ST_BURN_START_OX:
               if (is_abort) nxt = ST_ABORT_GROUND;
               else if (elapsed >= dur[REG_IGN_DELAY]) nxt = ST_BURN_START_FUEL;
            ST_BURN_START_FUEL:
               if (is_abort) nxt = ST_ABORT_GROUND;
               else if (elapsed >= dur[REG_RAMPUP]) nxt = ST_BURN;
            ST_BURN:
               if (is_abort) nxt = ST_ABORT_FLIGHT;
               else if (elapsed >= dur[REG_BURN_LIMIT]) nxt = ST_BURN_STOP_OX;
            ST_BURN_STOP_OX:
               if (is_abort) nxt = ST_ABORT_FLIGHT;
               else if (elapsed >= dur[REG_CUTOFF_DELAY]) nxt = ST_BURN_STOP_FUEL;
            ST_BURN_STOP_FUEL:
               nxt = is_abort ? ST_ABORT_FLIGHT : ST_WAIT_PASSIVATE;
            ST_WAIT_PASSIVATE:
               if (is_abort) nxt = ST_ABORT_FLIGHT;
               else if (cmd == CMD_PASSIVATE || elapsed >= dur[REG_NO_COMMS])
                  nxt = ST_SEPARATION_DELAY;
            ST_SEPARATION_DELAY:
               if (elapsed >= FIXED_STAGE_MS) nxt = ST_PASSIVATE_FUEL;
            ST_PASSIVATE_FUEL:
               if (elapsed >= FIXED_STAGE_MS) nxt = ST_PASSIVATE_CLOSE;
            ST_PASSIVATE_CLOSE:
               if (elapsed >= FIXED_STAGE_MS) nxt = ST_PASSIVATE_OX;
            ST_PASSIVATE_OX:
               if (elapsed >= FIXED_STAGE_MS) nxt = ST_SHUTOFF;
            ST_SHUTOFF:
               if (elapsed >= FIXED_STAGE_MS) nxt = ST_DEPRESSURIZE;
            ST_ABORT_GROUND:
               nxt = ST_GROUND_ABORT_OX;
            ST_GROUND_ABORT_OX:
               if (is_reset) nxt = ST_IDLE;
               else if (elapsed >= dur[REG_CUTOFF_DELAY]) nxt = ST_GROUND_ABORT_FUEL;
            ST_GROUND_ABORT_FUEL:
               if (is_reset) nxt = ST_IDLE;
            ST_ABORT_FLIGHT:
               nxt = ST_FLIGHT_ABORT_OX;
            ST_FLIGHT_ABORT_OX:
               if (elapsed >= dur[REG_CUTOFF_DELAY]) nxt = ST_FLIGHT_ABORT_FUEL;
            ST_FLIGHT_ABORT_FUEL:
               if (elapsed >= dur[REG_FLIGHT_HOLD]) nxt = ST_WAIT_PASSIVATE;
            ST_DEPRESSURIZE:
               if (is_reset) nxt = ST_IDLE;
            default:
               nxt = ST_ABORT_GROUND;
         endcase

         // Apply the valve and igniter actions of a newly entered state
         exp.state_changed = (nxt != state_q);
         if (nxt != state_q) begin
            entry_ms = now;
            case (nxt)
               ST_PRECHILL:          ox_latch = 1'b1;
               ST_IGNITER:           begin ox_latch = 1'b0; ign_latch = 1'b1; end
               ST_BURN_START_OX:     begin ox_latch = 1'b1; ign_latch = 1'b0; end
               ST_BURN_START_FUEL:   fuel_latch = 1'b1;
               ST_BURN_STOP_OX:      ox_latch = 1'b0;
               ST_BURN_STOP_FUEL:    fuel_latch = 1'b0;
               ST_PASSIVATE_FUEL:    fuel_latch = 1'b1;
               ST_PASSIVATE_CLOSE:   fuel_latch = 1'b0;
               ST_PASSIVATE_OX:      ox_latch = 1'b1;
               ST_SHUTOFF:           ox_latch = 1'b0;
               ST_GROUND_ABORT_OX:   ox_latch = 1'b0;
               ST_GROUND_ABORT_FUEL: fuel_latch = 1'b0;
               ST_FLIGHT_ABORT_OX:   ox_latch = 1'b0;
               ST_FLIGHT_ABORT_FUEL: fuel_latch = 1'b0;
               ST_DEPRESSURIZE:      begin ox_latch = 1'b1; fuel_latch = 1'b1; end
               default: ;
            endcase
         end
         state_q = nxt;
         exp.seq_state = state_q;
         exp.oxidizer_valve_open = ox_latch;
         exp.fuel_valve_open = fuel_latch;
         exp.igniter_on = ign_latch;
         expected_words.push_back(exp);
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // Compare one returned word against the oldest expectation
      task check_word(result_type got);
         result_type exp;
         if (expected_words.size() == 0) begin
            report($sformatf("word with nothing pending, state %0d", got.seq_state));
         end else begin
            exp = expected_words.pop_front();
            if (got.seq_state !== exp.seq_state)
               report($sformatf("seq_state got %0d expected %0d",
                                got.seq_state, exp.seq_state));
            if (got.oxidizer_valve_open !== exp.oxidizer_valve_open)
               report($sformatf("oxidizer_valve_open got %b expected %b",
                                got.oxidizer_valve_open, exp.oxidizer_valve_open));
            if (got.fuel_valve_open !== exp.fuel_valve_open)
               report($sformatf("fuel_valve_open got %b expected %b",
                                got.fuel_valve_open, exp.fuel_valve_open));
            if (got.igniter_on !== exp.igniter_on)
               report($sformatf("igniter_on got %b expected %b",
                                got.igniter_on, exp.igniter_on));
            if (got.state_changed !== exp.state_changed)
               report($sformatf("state_changed got %b expected %b",
                                got.state_changed, exp.state_changed));
         end
      endtask
   endclass

   ignition_checker sb;
   logic [TW-1:0]   clock_ms;
   bit              quiet;

   engine_ignition_sequencer #(.TIME_BITS(TW)) DUT (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_now_ms              (req_now_ms),
      .req_command             (req_command),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_seq_state           (rsp_seq_state),
      .rsp_oxidizer_valve_open (rsp_oxidizer_valve_open),
      .rsp_fuel_valve_open     (rsp_fuel_valve_open),
      .rsp_igniter_on          (rsp_igniter_on),
      .rsp_state_changed       (rsp_state_changed),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stall the result side in random bursts, never once the run goes quiet
   initial begin
      int left;
      rsp_ready <= 1'b0;
      left = 0;
      forever begin
         @(posedge clock);
         if (left > 0) begin
            left--;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            left = $urandom_range(1, 40);
         end else begin
            rsp_ready <= 1'b0;
            left = $urandom_range(0, 13);
         end
      end
   end

   // Check every returned word
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word(result_type'({rsp_seq_state, rsp_oxidizer_valve_open,
                                     rsp_fuel_valve_open, rsp_igniter_on,
                                     rsp_state_changed}));
   end

   // Offer one word, with an occasional random gap before it, and hold until taken
   task automatic send_word(logic [TW-1:0] now, cmd_type cmd);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_now_ms  <= now;
      req_command <= cmd;
      do @(posedge clock); while (!req_ready);
      sb.note_word(now, cmd);
   endtask

   // Hold off the sender until every expected word is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic [CFG_BITS-1:0] pick_duration(dur_mode_type mode);
      case (mode)
         DUR_ZERO:  return '0;
         DUR_MAX:   return '1;
         DUR_SMALL: return $urandom_range(0, 40);
         default:
            case ($urandom_range(0, 6))
               0:       return '0;
               1:       return 32'd1;
               2:       return $urandom_range(0, 40);
               3:       return CFG_RESET_MS;
               4:       return 32'hFFFF_FFFF;
               5:       return 32'hFFFF_FFFE;
               default: return $urandom();
            endcase
      endcase
   endfunction

   // Write all stage durations; call only with nothing in flight
   task automatic program_regs(dur_mode_type mode);
      int                  i;
      logic [CFG_BITS-1:0] val;
      for (i = REG_PRECHILL; i <= REG_FLIGHT_HOLD; i++) begin
         val = pick_duration(mode);
         csr_valid <= 1'b1;
         csr_index <= cfg_index_type'(i);
         csr_wdata <= val;
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(cfg_index_type'(i), val);
      end
      csr_valid <= 1'b0;
   endtask

   // Mostly steer the engine forward, with aborts, resets and noise mixed in
   function automatic cmd_type pick_command();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) return cmd_type'($urandom_range(0, 7));
      if (roll < 16) return CMD_ABORT;
      case (sb.state_q)
         ST_IDLE:            return CMD_CLEAR;
         ST_CLEAR_TO_IGNITE: return CMD_IGNITE;
         ST_WAIT_PASSIVATE:  return (roll < 40) ? CMD_PASSIVATE : CMD_NONE;
         ST_GROUND_ABORT_OX, ST_GROUND_ABORT_FUEL, ST_DEPRESSURIZE:
            return (roll < 30) ? CMD_RESET : CMD_NONE;
         default:            return CMD_NONE;
      endcase
   endfunction

   // Step the time base; often land right at a stage boundary
   function automatic logic [TW-1:0] pick_time(logic [TW-1:0] last);
      int                  k;
      logic [CFG_BITS-1:0] span;
      case ($urandom_range(0, 9))
         0:       return last;
         1, 2:    return last + $urandom_range(0, 64);
         3:       return last + $urandom_range(9990, 10010);
         4:       return $urandom();
         5, 6, 7: begin
            k = $urandom_range(0, REG_FLIGHT_HOLD + 1);
            span = (k > REG_FLIGHT_HOLD) ? FIXED_STAGE_MS : sb.dur[k];
            return sb.entry_ms + span + $urandom_range(0, 2) - 1;
         end
         default: return last + $urandom_range(0, 2000);
      endcase
   endfunction

   task automatic run_random(int count);
      int n;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 299) == 0) drain_results();
         clock_ms = pick_time(clock_ms);
         send_word(clock_ms, pick_command());
      end
   endtask

   initial begin
      sb = new();
      quiet = 1'b0;
      clock_ms = '0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_now_ms  <= '0;
      req_command <= CMD_NONE;
      csr_valid   <= 1'b0;
      csr_index   <= REG_PRECHILL;
      csr_wdata   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed words on the reset durations
      send_word(32'd0, CMD_NONE);
      send_word(32'hFFFF_FFFF, CMD_SPARE_7);
      send_word(32'hFFFF_FFFF, CMD_SPARE_6);
      send_word(32'hFFFF_FFFF, CMD_CLEAR);
      // commands with no meaning here are ignored
      send_word(32'd0, CMD_PASSIVATE);
      send_word(32'd0, CMD_RESET);
      send_word(32'd5, CMD_IGNITE);
      // one short of the prechill, then exactly on it
      send_word(32'd10004, CMD_NONE);
      send_word(32'd10005, CMD_NONE);
      // abort wins over an expired igniter stage
      send_word(32'd20005, CMD_ABORT);
      send_word(32'd20005, CMD_RESET);
      // reset wins over an expired cutoff delay
      send_word(32'd30005, CMD_RESET);
      send_word(32'd30005, CMD_CLEAR);
      send_word(32'd30005, CMD_IGNITE);
      // time going back wraps to a huge elapsed time
      send_word(32'd30004, CMD_NONE);
      send_word(32'd30004, CMD_ABORT);
      send_word(32'd30004, CMD_NONE);
      send_word(32'd40004, CMD_NONE);
      send_word(32'd40004, CMD_ABORT);
      send_word(32'd40004, CMD_RESET);
      drain_results();

      // Random phases over several duration settings
      program_regs(DUR_SMALL);
      run_random(500);
      drain_results();
      program_regs(DUR_ZERO);
      run_random(300);
      drain_results();
      program_regs(DUR_MAX);
      run_random(300);
      drain_results();
      program_regs(DUR_MIXED);
      run_random(400);
      drain_results();
      program_regs(DUR_SMALL);
      quiet = 1'b1;
      run_random(400);

      drain_results();
      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d words never returned", sb.pending()));
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Bound the run
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// File: filelist.f
src/eis_pkg.sv
src/eis_cfg_regs.sv
src/eis_core.sv
src/engine_ignition_sequencer.sv
src/eis_checker.sv
verif/tb_engine_ignition_sequencer.sv
